@@ sv/gmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_pkg
// Types, codes and helpers shared by the membership table modules.
// ----------------------------------------------------------------------------
package gmt_pkg;

  localparam int TableDepth = 32;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_JOIN  = 2'd1,
    ACT_MERGE = 2'd2,
    ACT_ENTER = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_GOSSIP  = 3'd1,
    KIND_REMOVED = 3'd2,
    KIND_ADDED   = 3'd3,
    KIND_LISTED  = 3'd4,
    KIND_FULL    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SELF_ID       = 2'd0,
    CFG_SELF_PORT     = 2'd1,
    CFG_FAIL_WINDOW   = 2'd2,
    CFG_REMOVE_WINDOW = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_RESOLVE,
    ST_MARK_RD,
    ST_MARK_EV,
    ST_RM_RD,
    ST_RM_EV,
    ST_GOS_RD,
    ST_GOS_EV,
    ST_LIST_RD,
    ST_LIST_EV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] now;
    logic [7:0]  entry_id;
    logic [15:0] entry_port;
    logic [31:0] entry_heartbeat;
    logic [31:0] entry_timestamp;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  member_id;
    logic [15:0] member_port;
    logic [31:0] member_heartbeat;
    logic [31:0] member_timestamp;
    logic [5:0]  member_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] port;
    logic [31:0] heartbeat;
    logic [31:0] timestamp;
  } slot_t;

  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  rd;
    logic  scan;
    logic  mark;
    logic  emit;
    kind_t emit_kind;
    logic  resolve;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    in_group;
    logic    idx_last;
    logic    out_free;
    logic    hold_valid;
    logic    sel_rm;
    logic    sel_gossip;
    logic    sel_list;
  } sts_t;

  // True when the timestamp lies more than the window behind now.
  function automatic logic older(input logic [31:0] ts, input logic [31:0] now,
                                 input logic [15:0] win);
    logic [31:0] w;
    w = {16'd0, win};
    return (now >= w) && (ts < now - w);
  endfunction

endpackage

@@ sv/gmt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_ctrl
// Sequencer that walks the table for each request and issues datapath commands.
// ----------------------------------------------------------------------------
module gmt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  gmt_pkg::action_t in_action,
  output logic            in_stall,
  input  gmt_pkg::sts_t   sts,
  output gmt_pkg::cmd_t   cmd
);
  import gmt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic   walk;
    logic   ev_sel;
    kind_t  ev_kind;
    state_t ev_rd;
    state_t ev_done;
    cmd        = '0;
    state_next = state;
    in_stall   = (state != ST_IDLE);
    walk       = 1'b0;
    ev_sel     = 1'b0;
    ev_kind    = KIND_DONE;
    ev_rd      = ST_IDLE;
    ev_done    = ST_FINISH;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = (in_action == ACT_TICK) ? ST_MARK_RD : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_RESOLVE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_SCAN_RD;
        end
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = (sts.action == ACT_JOIN) ? ST_LIST_RD : ST_FINISH;
      end
      ST_MARK_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_MARK_EV;
      end
      ST_MARK_EV: begin
        cmd.mark = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = sts.in_group ? ST_RM_RD : ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_MARK_RD;
        end
      end
      ST_RM_RD, ST_GOS_RD, ST_LIST_RD: begin
        cmd.rd     = 1'b1;
        state_next = state_t'(state + 4'd1);
      end
      ST_RM_EV: begin
        walk    = 1'b1;
        ev_sel  = sts.sel_rm;
        ev_kind = KIND_REMOVED;
        ev_rd   = ST_RM_RD;
        ev_done = ST_GOS_RD;
      end
      ST_GOS_EV: begin
        walk    = 1'b1;
        ev_sel  = sts.sel_gossip;
        ev_kind = KIND_GOSSIP;
        ev_rd   = ST_GOS_RD;
      end
      ST_LIST_EV: begin
        walk    = 1'b1;
        ev_sel  = sts.sel_list;
        ev_kind = KIND_LISTED;
        ev_rd   = ST_LIST_RD;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // A held result must drain before a new one can take its place.
    if (walk && !(ev_sel && sts.hold_valid && !sts.out_free)) begin
      cmd.emit      = ev_sel;
      cmd.emit_kind = ev_kind;
      if (sts.idx_last) begin
        cmd.idx_clr = 1'b1;
        state_next  = ev_done;
      end else begin
        cmd.idx_inc = 1'b1;
        state_next  = ev_rd;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_MARK_RD || state == ST_SCAN_RD))
    else $error("request accepted without starting a walk");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && sts.out_free) |=> (state == ST_IDLE))
    else $error("finish did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESOLVE) |=> (state == ST_LIST_RD || state == ST_FINISH))
    else $error("resolve went to an unexpected state");

endmodule

@@ sv/gmt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_dp
// Slot memory, valid bits, configuration, result holding and output register.
// ----------------------------------------------------------------------------
module gmt_dp #(
  parameter int TABLE_DEPTH = gmt_pkg::TableDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  gmt_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gmt_pkg::out_item_t out_data,
  input  gmt_pkg::cmd_t      cmd,
  output gmt_pkg::sts_t      sts
);
  import gmt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  slot_t mem [TABLE_DEPTH];
  slot_t rd_data;

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] rm;
  logic [CW-1:0]          count;
  logic [IW-1:0]          idx;

  in_item_t    item;
  logic [31:0] own_hb;
  logic        in_group;
  logic [7:0]  self_id;
  logic [15:0] self_port;
  logic [15:0] fail_window;
  logic [15:0] remove_window;

  logic          hit;
  logic [IW-1:0] hit_idx;
  slot_t         hit_data;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          self_done;

  logic  hold_valid;
  kind_t hold_kind;
  slot_t hold_slot;

  logic          out_free;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;
  logic          mark_self;
  logic          mark_rm;
  logic [7:0]    key;
  logic          res_add;
  logic          res_wr;
  kind_t         res_kind;
  slot_t         res_slot;
  slot_t         add_slot;
  logic [CW+5:0] count_ext;

  assign out_free  = !out_valid || !out_stall;
  assign key       = (item.action == ACT_ENTER) ? self_id : item.entry_id;
  assign count_ext = {6'd0, count};

  assign mark_self = valid[idx] && (rd_data.id == self_id) && !self_done;
  assign mark_rm   = valid[idx] && (rd_data.id != self_id) && in_group
                     && older(rd_data.timestamp, item.now, remove_window);

  assign sts.action     = item.action;
  assign sts.in_group   = in_group;
  assign sts.idx_last   = (idx == IW'(TABLE_DEPTH - 1));
  assign sts.out_free   = out_free;
  assign sts.hold_valid = hold_valid;
  assign sts.sel_rm     = rm[idx];
  assign sts.sel_gossip = valid[idx] && (rd_data.id != self_id)
                          && !older(rd_data.timestamp, item.now, fail_window);
  assign sts.sel_list   = valid[idx];

  // Outcome of a join, merge or enter once the scan has finished.
  always_comb begin
    res_add  = 1'b0;
    res_wr   = 1'b0;
    res_kind = KIND_DONE;
    res_slot = '0;
    add_slot = '0;
    case (item.action)
      ACT_JOIN: begin
        res_add  = 1'b1;
        add_slot = '{item.entry_id, item.entry_port, item.entry_heartbeat, item.now};
      end
      ACT_MERGE: begin
        if (hit) begin
          res_slot = hit_data;
          if (item.entry_heartbeat > hit_data.heartbeat) begin
            res_wr             = 1'b1;
            res_slot.heartbeat = item.entry_heartbeat;
            res_slot.timestamp = item.now;
          end
        end else if (!older(item.entry_timestamp, item.now, fail_window)) begin
          res_add  = 1'b1;
          add_slot = '{item.entry_id, item.entry_port, item.entry_heartbeat,
                       item.entry_timestamp};
        end else begin
          res_slot = '{item.entry_id, item.entry_port, item.entry_heartbeat,
                       item.entry_timestamp};
        end
      end
      ACT_ENTER: begin
        if (hit) begin
          res_slot = hit_data;
        end else begin
          res_add  = 1'b1;
          add_slot = '{self_id, self_port, own_hb, item.now};
        end
      end
      default: ;
    endcase
    if (res_add) begin
      res_slot = add_slot;
      res_kind = free_found ? KIND_ADDED : KIND_FULL;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    if (cmd.mark && mark_self) begin
      wr_en             = 1'b1;
      wr_data.heartbeat = own_hb;
      wr_data.timestamp = item.now;
    end else if (cmd.resolve && res_wr) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx;
      wr_data = res_slot;
    end else if (cmd.resolve && res_add && free_found) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = add_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      self_id       <= 8'd1;
      self_port     <= 16'd0;
      fail_window   <= 16'd5;
      remove_window <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SELF_ID:       self_id       <= cfg_data[7:0];
        CFG_SELF_PORT:     self_port     <= cfg_data;
        CFG_FAIL_WINDOW:   fail_window   <= cfg_data;
        CFG_REMOVE_WINDOW: remove_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.scan) begin
      if (valid[idx] && (rd_data.id == key) && !hit) begin
        hit_idx  <= idx;
        hit_data <= rd_data;
      end
      if (!valid[idx] && !free_found) begin
        free_idx <= idx;
      end
    end
    if (cmd.emit) begin
      hold_kind <= cmd.emit_kind;
      hold_slot <= rd_data;
    end else if (cmd.resolve) begin
      hold_kind <= res_kind;
      hold_slot <= res_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rm         <= '0;
      count      <= '0;
      idx        <= '0;
      own_hb     <= '0;
      in_group   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      self_done  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.load) begin
        rm         <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        self_done  <= 1'b0;
        if (in_data.action == ACT_TICK) begin
          own_hb <= own_hb + 32'd1;
        end
      end
      if (cmd.scan) begin
        if (valid[idx] && (rd_data.id == key)) begin
          hit <= 1'b1;
        end
        if (!valid[idx]) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.mark) begin
        if (mark_self) begin
          self_done <= 1'b1;
        end else if (mark_rm) begin
          valid[idx] <= 1'b0;
          rm[idx]    <= 1'b1;
          count      <= count - CW'(1);
        end
      end
      if (cmd.resolve) begin
        hold_valid <= 1'b1;
        if (item.action == ACT_ENTER) begin
          in_group <= 1'b1;
        end
        if (res_add && free_found) begin
          valid[free_idx] <= 1'b1;
          count           <= count + CW'(1);
        end
      end
      if (cmd.emit) begin
        hold_valid <= 1'b1;
      end else if (cmd.finish) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Output register. A new result pushes the held one out; finish pushes the
  // held one, or an empty done result, marked as the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.emit && hold_valid) || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit && hold_valid) || cmd.finish) begin
      out_data.kind             <= hold_valid ? hold_kind : KIND_DONE;
      out_data.member_id        <= hold_valid ? hold_slot.id : 8'd0;
      out_data.member_port      <= hold_valid ? hold_slot.port : 16'd0;
      out_data.member_heartbeat <= hold_valid ? hold_slot.heartbeat : 32'd0;
      out_data.member_timestamp <= hold_valid ? hold_slot.timestamp : 32'd0;
      out_data.member_count     <= count_ext[5:0];
      out_data.last             <= cmd.finish;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("member count disagrees with valid bits");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && hold_valid && !out_free))
    else $error("held result overwritten while output is busy");

  assert property (@(posedge clk) disable iff (rst)
    (rm & valid) == '0)
    else $error("removed slot still marked valid");

endmodule

@@ sv/gossip_membership_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gossip_membership_table
// Bounded member table for gossip heartbeat failure detection.
// ----------------------------------------------------------------------------
// One request is handled at a time, by walking the slot memory through its
// single read port, each slot being read and then evaluated. Merge and enter
// make a scan pass, a join a scan pass and a listing pass, a tick out of
// the group a self update pass and a tick in the group the self update and
// expiry pass, the removal report pass and the gossip report pass; a walk
// waits while the output is stalled. Every request ends with a result marked
// last; member_count on each result is the table fill after the whole
// request. No clearing pass is needed after reset.
module gossip_membership_table #(
  parameter int TABLE_DEPTH = gmt_pkg::TableDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gmt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gmt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_action(in_data.action),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gmt_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

@@ test/gmt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmt_checker
// Watches both channels of the membership table, keeps its own copy of the
// table, predicts the results of every accepted request and compares them.
// ----------------------------------------------------------------------------
module gmt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  gmt_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  gmt_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import gmt_pkg::*;

  localparam int Depth = TableDepth;

  logic        tbl_valid [Depth];
  slot_t       tbl_slot [Depth];
  logic [31:0] own_hb;
  logic        joined;
  logic [7:0]  my_id;
  logic [15:0] my_port;
  logic [15:0] dead_win;
  logic [15:0] drop_win;

  out_item_t results_due[$];

  assign pending = results_due.size();

  function automatic bit aged(logic [31:0] ts, logic [31:0] now, logic [15:0] win);
    return (now >= {16'd0, win}) && (ts < now - {16'd0, win});
  endfunction

  function automatic int lookup(logic [7:0] id);
    for (int i = 0; i < Depth; i++)
      if (tbl_valid[i] && tbl_slot[i].id == id) return i;
    return -1;
  endfunction

  function automatic kind_t store(slot_t s);
    for (int i = 0; i < Depth; i++)
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_slot[i] = s;
        return KIND_ADDED;
      end
    return KIND_FULL;
  endfunction

  task automatic predict_request(in_item_t req);
    out_item_t batch[$];
    out_item_t r;
    slot_t     s;
    int        k;
    int        cnt;
    kind_t     kd;
    r = '0;
    case (req.action)
      ACT_TICK: begin
        own_hb = own_hb + 32'd1;
        k = lookup(my_id);
        if (k >= 0) begin
          tbl_slot[k].heartbeat = own_hb;
          tbl_slot[k].timestamp = req.now;
        end
        if (joined) begin
          for (int i = 0; i < Depth; i++)
            if (tbl_valid[i] && tbl_slot[i].id != my_id &&
                aged(tbl_slot[i].timestamp, req.now, drop_win)) begin
              tbl_valid[i] = 1'b0;
              r = '0;
              r.kind = KIND_REMOVED;
              {r.member_id, r.member_port, r.member_heartbeat, r.member_timestamp} =
                tbl_slot[i];
              batch = {batch, r};
            end
          for (int i = 0; i < Depth; i++)
            if (tbl_valid[i] && tbl_slot[i].id != my_id &&
                !aged(tbl_slot[i].timestamp, req.now, dead_win)) begin
              r = '0;
              r.kind = KIND_GOSSIP;
              {r.member_id, r.member_port, r.member_heartbeat, r.member_timestamp} =
                tbl_slot[i];
              batch = {batch, r};
            end
        end
        if (batch.size() == 0) begin
          r = '0;
          r.kind = KIND_DONE;
          batch = {batch, r};
        end
      end
      ACT_JOIN: begin
        s = '{req.entry_id, req.entry_port, req.entry_heartbeat, req.now};
        r = '0;
        r.kind = store(s);
        {r.member_id, r.member_port, r.member_heartbeat, r.member_timestamp} = s;
        batch = {batch, r};
        for (int i = 0; i < Depth; i++)
          if (tbl_valid[i]) begin
            r = '0;
            r.kind = KIND_LISTED;
            {r.member_id, r.member_port, r.member_heartbeat, r.member_timestamp} =
              tbl_slot[i];
            batch = {batch, r};
          end
      end
      ACT_MERGE: begin
        k = lookup(req.entry_id);
        s = '{req.entry_id, req.entry_port, req.entry_heartbeat, req.entry_timestamp};
        r = '0;
        if (k >= 0) begin
          if (req.entry_heartbeat > tbl_slot[k].heartbeat) begin
            tbl_slot[k].heartbeat = req.entry_heartbeat;
            tbl_slot[k].timestamp = req.now;
          end
          s = tbl_slot[k];
          kd = KIND_DONE;
        end else if (!aged(req.entry_timestamp, req.now, dead_win)) begin
          kd = store(s);
        end else begin
          kd = KIND_DONE;
        end
        r.kind = kd;
        {r.member_id, r.member_port, r.member_heartbeat, r.member_timestamp} = s;
        batch = {batch, r};
      end
      default: begin
        joined = 1'b1;
        k = lookup(my_id);
        r = '0;
        if (k >= 0) begin
          s = tbl_slot[k];
          r.kind = KIND_DONE;
        end else begin
          s = '{my_id, my_port, own_hb, req.now};
          r.kind = store(s);
        end
        {r.member_id, r.member_port, r.member_heartbeat, r.member_timestamp} = s;
        batch = {batch, r};
      end
    endcase
    cnt = 0;
    for (int i = 0; i < Depth; i++) if (tbl_valid[i]) cnt++;
    foreach (batch[i]) begin
      batch[i].member_count = 6'(cnt);
      batch[i].last = (i == batch.size() - 1);
      results_due = {results_due, batch[i]};
    end
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      $error("unexpected result: kind %0d id %0d", got.kind, got.member_id);
      fail_count++;
      return;
    end
    want = results_due.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d actual %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.member_id !== want.member_id) begin
      $error("member_id: expected %0d actual %0d", want.member_id, got.member_id);
      fail_count++;
    end
    if (got.member_port !== want.member_port) begin
      $error("member_port: expected %0d actual %0d", want.member_port, got.member_port);
      fail_count++;
    end
    if (got.member_heartbeat !== want.member_heartbeat) begin
      $error("member_heartbeat: expected %0d actual %0d", want.member_heartbeat,
             got.member_heartbeat);
      fail_count++;
    end
    if (got.member_timestamp !== want.member_timestamp) begin
      $error("member_timestamp: expected %0d actual %0d", want.member_timestamp,
             got.member_timestamp);
      fail_count++;
    end
    if (got.member_count !== want.member_count) begin
      $error("member_count: expected %0d actual %0d", want.member_count,
             got.member_count);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d actual %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) tbl_valid[i] = 1'b0;
      own_hb = '0;
      joined = 1'b0;
      my_id = 8'd1;
      my_port = 16'd0;
      dead_win = 16'd5;
      drop_win = 16'd20;
      fail_count = 0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SELF_ID:     my_id = cfg_data[7:0];
          CFG_SELF_PORT:   my_port = cfg_data;
          CFG_FAIL_WINDOW: dead_win = cfg_data;
          default:         drop_win = cfg_data;
        endcase
      end
      // Results are compared before the new request is predicted; a result
      // of the new request cannot appear in the same cycle it is accepted.
      if (out_valid && !out_stall) compare_result(out_data);
      if (in_valid && !in_stall) predict_request(in_data);
    end
  end

endmodule

@@ test/tb_gossip_membership_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gossip_membership_table
// Drives directed and random requests into the membership table under
// several idle and stall patterns, with register changes between phases.
// ----------------------------------------------------------------------------
module tb_gossip_membership_table;
  import gmt_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int fail_count;
  int pending;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  logic [31:0] clock_now = 32'd100;
  logic [7:0]  id_pool [8];

  always #6 clk = ~clk;

  gossip_membership_table DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gmt_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Valid drops at the falling edge after acceptance, and the task waits out
  // another falling edge before it returns, so the next request never drives valid in the same step.
  task automatic send(action_t act, logic [31:0] now, logic [7:0] id,
                      logic [15:0] port, logic [31:0] hb, logic [31:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{act, now, id, port, hb, ts};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic random_request();
    int pick;
    logic [7:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? 8'($urandom) : id_pool[$urandom_range(7)];
    clock_now = clock_now + $urandom_range(4);
    if ($urandom_range(49) == 0) clock_now = $urandom;
    if (pick < 35)
      send(ACT_TICK, clock_now, id, 16'($urandom), $urandom, $urandom);
    else if (pick < 55)
      send(ACT_JOIN, clock_now, id, 16'($urandom), $urandom, $urandom);
    else if (pick < 93)
      send(ACT_MERGE, clock_now, id, 16'($urandom),
           ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(60)),
           ($urandom_range(7) == 0) ? $urandom : clock_now - $urandom_range(10));
    else
      send(ACT_ENTER, clock_now, id, 16'($urandom), $urandom, $urandom);
  endtask

  initial begin
    #20_000_000;
    $display("gossip_membership_table: mismatch");
    $finish;
  end

  initial begin
    foreach (id_pool[i]) id_pool[i] = 8'($urandom);
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: defaults, out of group, then fill the table to overflow.
    send(ACT_TICK, 32'd0, 8'd0, 16'd0, 32'd0, 32'd0);
    send(ACT_MERGE, 32'd3, 8'd0, 16'd0, 32'd0, 32'd0);
    send(ACT_MERGE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
    send(ACT_MERGE, 32'd10, 8'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_MERGE, 32'd11, 8'd7, 16'd1, 32'd5, 32'd11);
    send(ACT_JOIN, 32'd12, 8'd1, 16'd0, 32'd0, 32'd0);
    send(ACT_ENTER, 32'd13, 8'd0, 16'd0, 32'd0, 32'd0);
    send(ACT_TICK, 32'd14, 8'd0, 16'd0, 32'd0, 32'd0);
    for (int i = 0; i < 30; i++)
      send(ACT_MERGE, 32'd15, 8'(20 + i), 16'(i), 32'(i), 32'd15);
    send(ACT_JOIN, 32'd16, 8'd99, 16'd9, 32'd9, 32'd0);
    send(ACT_MERGE, 32'd16, 8'd200, 16'd9, 32'd9, 32'd16);
    send(ACT_TICK, 32'd60, 8'd0, 16'd0, 32'd0, 32'd0);
    send(ACT_TICK, 32'd61, 8'd0, 16'd0, 32'd0, 32'd0);
    drain();

    write_reg(CFG_SELF_ID, 16'h00FF);
    write_reg(CFG_SELF_PORT, 16'hFFFF);
    write_reg(CFG_FAIL_WINDOW, 16'd1);
    write_reg(CFG_REMOVE_WINDOW, 16'd1);
    send(ACT_ENTER, 32'd70, 8'd0, 16'd0, 32'd0, 32'd0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        3: begin idle_pct = 11; stall_pct = 11; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 48; i++) random_request();
      drain();
      write_reg(CFG_SELF_ID, 16'(id_pool[$urandom_range(7)]));
      write_reg(CFG_SELF_PORT, 16'($urandom));
      write_reg(CFG_FAIL_WINDOW, (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 12)));
      write_reg(CFG_REMOVE_WINDOW, (ph == 1) ? 16'hFFFF : 16'($urandom_range(2, 30)));
    end

    drain();
    if (fail_count == 0)
      $display("gossip_membership_table: match");
    else
      $display("gossip_membership_table: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
sv/gmt_pkg.sv
sv/gmt_ctrl.sv
sv/gmt_dp.sv
sv/gossip_membership_table.sv
test/gmt_checker.sv
test/tb_gossip_membership_table.sv
